[design/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and control types for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   // operation codes carried by req_kind
   localparam logic [1:0] KIND_ENQ   = 2'd0;
   localparam logic [1:0] KIND_DEQ   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic enq;
      logic deq;
      logic clear;
      logic load_rsp;
   } spq_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic full;
   } spq_stat_type;

endpackage

[design/stable_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, lowest number first, ties leave in arrival order.
// ----------------------------------------------------------------------------
// A result becomes valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless the receiver stalls a result;
//   every cell of the shift chain compares against the new entry in
//   parallel, so each insert or removal finishes in the accepting cycle.
// Reset: the entry count and response state clear at once; cell contents
//   stay undefined and are never read before they are written.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 4,
   parameter int PAYLOAD_BITS  = 32
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [PAYLOAD_BITS-1:0]        req_entry_payload,
   input  logic [PRIORITY_BITS-1:0]       req_entry_priority,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [PAYLOAD_BITS-1:0]        rsp_out_payload,
   output logic [PRIORITY_BITS-1:0]       rsp_out_priority,
   output logic [1:0]                     rsp_status,
   output logic [$clog2(DEPTH + 1)-1:0]   rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   spq_cmd_type  dp_cmd;
   spq_stat_type dp_stat;
   logic         accept;

   assign accept = req_valid && !req_stall;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   spq_datapath #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .CNT_W         (CNT_W)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_stat            (dp_stat),
      .req_entry_payload  (req_entry_payload),
      .req_entry_priority (req_entry_priority),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_occupancy      (rsp_occupancy)
   );

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no response");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_W'(DEPTH)))
      else $error("occupancy above depth");

   a_no_enq_full: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.enq |-> !dp_stat.full)
      else $error("insert issued into a full queue");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_DEQ) && dp_stat.empty)
         |=> (rsp_status == STATUS_EMPTY) && (rsp_out_payload == '0))
      else $error("dequeue on empty queue reported wrongly");

endmodule

[design/spq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: decodes the operation, picks the status code and
// owns the response valid state.
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_kind,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   input  spq_stat_type dp_stat,
   output spq_cmd_type  dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       accept;

   // hold new transactions only while a result sits unconsumed
   assign req_stall = (state_ff == ST_RESP) && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      dp_cmd          = '0;
      dp_cmd.load_rsp = accept;
      status_in       = status_ff;
      if (accept) begin
         status_in = STATUS_DONE;
         unique case (req_kind)
            KIND_ENQ: begin
               if (dp_stat.full) status_in = STATUS_FULL;
               else              dp_cmd.enq = 1'b1;
            end
            KIND_DEQ: begin
               if (dp_stat.empty) status_in = STATUS_EMPTY;
               else               dp_cmd.deq = 1'b1;
            end
            KIND_CLEAR: dp_cmd.clear = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RESP;
         ST_RESP: if (!accept && !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_status = status_ff;

endmodule

[design/spq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted shift chain of cells, entry counter and response registers.
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 4,
   parameter int PAYLOAD_BITS  = 32,
   parameter int CNT_W         = $clog2(DEPTH + 1)
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  spq_cmd_type              dp_cmd,
   output spq_stat_type             dp_stat,
   input  logic [PAYLOAD_BITS-1:0]  req_entry_payload,
   input  logic [PRIORITY_BITS-1:0] req_entry_priority,
   output logic [PAYLOAD_BITS-1:0]  rsp_out_payload,
   output logic [PRIORITY_BITS-1:0] rsp_out_priority,
   output logic [CNT_W-1:0]         rsp_occupancy
);

   logic [PAYLOAD_BITS-1:0]  payload_ff [DEPTH];
   logic [PAYLOAD_BITS-1:0]  payload_in [DEPTH];
   logic [PRIORITY_BITS-1:0] prio_ff    [DEPTH];
   logic [PRIORITY_BITS-1:0] prio_in    [DEPTH];
   logic [DEPTH-1:0]         behind;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PAYLOAD_BITS-1:0]  out_payload_ff, out_payload_in;
   logic [PRIORITY_BITS-1:0] out_prio_ff, out_prio_in;
   logic [CNT_W-1:0]         occ_ff, occ_in;

   assign dp_stat.empty = (count_ff == '0);
   assign dp_stat.full  = (count_ff == CNT_W'(DEPTH));

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

      // empty cells and cells with a strictly larger number move back
      assign behind[i] = (count_ff <= IDX) || (prio_ff[i] > req_entry_priority);

      always_comb begin
         payload_in[i] = payload_ff[i];
         prio_in[i]    = prio_ff[i];
         if (dp_cmd.enq && behind[i]) begin
            payload_in[i] = req_entry_payload;
            prio_in[i]    = req_entry_priority;
            if (i > 0) begin
               if (behind[(i > 0) ? i - 1 : 0]) begin
                  payload_in[i] = payload_ff[(i > 0) ? i - 1 : 0];
                  prio_in[i]    = prio_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else if (dp_cmd.deq && (i < DEPTH - 1)) begin
            // advance toward the head
            payload_in[i] = payload_ff[(i < DEPTH - 1) ? i + 1 : i];
            prio_in[i]    = prio_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         payload_ff[i] <= payload_in[i];
         prio_ff[i]    <= prio_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.clear)    count_in = '0;
      else if (dp_cmd.enq) count_in = count_ff + CNT_W'(1);
      else if (dp_cmd.deq) count_in = count_ff - CNT_W'(1);
   end

   always_comb begin
      out_payload_in = out_payload_ff;
      out_prio_in    = out_prio_ff;
      occ_in         = occ_ff;
      if (dp_cmd.load_rsp) begin
         out_payload_in = dp_cmd.deq ? payload_ff[0] : '0;
         out_prio_in    = dp_cmd.deq ? prio_ff[0] : '0;
         occ_in         = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_payload_ff <= out_payload_in;
      out_prio_ff    <= out_prio_in;
      occ_ff         <= occ_in;
   end

   assign rsp_out_payload  = out_payload_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

[bench/spq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches both channels of the stable priority queue, keeps its own sorted
// copy of the queue, predicts one response per accepted request and compares
// every accepted response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module spq_result_checker
   import spq_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 4,
   parameter int PAYLOAD_BITS  = 32,
   parameter int OCC_BITS      = $clog2(DEPTH + 1)
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [PAYLOAD_BITS-1:0]   req_entry_payload,
   input  logic [PRIORITY_BITS-1:0]  req_entry_priority,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [PAYLOAD_BITS-1:0]   rsp_out_payload,
   input  logic [PRIORITY_BITS-1:0]  rsp_out_priority,
   input  logic [1:0]                rsp_status,
   input  logic [OCC_BITS-1:0]       rsp_occupancy,
   output int                        fail_count,
   output int                        pending_count
);

   localparam int MAX_PRINTED = 20;

   typedef struct {
      logic [PAYLOAD_BITS-1:0]  payload;
      logic [PRIORITY_BITS-1:0] prio;
      logic [1:0]               status;
      logic [OCC_BITS-1:0]      occupancy;
   } queue_rsp_type;

   // sorted copy of the queue, head at index 0
   logic [PAYLOAD_BITS-1:0]  held_payload [DEPTH];
   logic [PRIORITY_BITS-1:0] held_prio    [DEPTH];
   int                       held_count;

   queue_rsp_type awaited_rsps [$];
   queue_rsp_type want;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] wanted);
      if (fail_count < MAX_PRINTED)
         $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, wanted);
      fail_count++;
   endtask

   // apply one transaction to the queue copy and queue the response it gives
   task automatic predict_result(input logic [1:0] kind,
                                 input logic [PAYLOAD_BITS-1:0] payload,
                                 input logic [PRIORITY_BITS-1:0] prio);
      queue_rsp_type rsp;
      int            pos;
      rsp.payload = '0;
      rsp.prio    = '0;
      rsp.status  = STATUS_DONE;
      case (kind)
         KIND_ENQ: begin
            if (held_count >= DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               // insert behind every entry of equal or lower number
               pos = 0;
               while (pos < held_count && held_prio[pos] <= prio)
                  pos++;
               for (int i = held_count; i > pos; i--) begin
                  held_payload[i] = held_payload[i-1];
                  held_prio[i]    = held_prio[i-1];
               end
               held_payload[pos] = payload;
               held_prio[pos]    = prio;
               held_count++;
            end
         end
         KIND_DEQ: begin
            if (held_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.payload = held_payload[0];
               rsp.prio    = held_prio[0];
               for (int i = 0; i + 1 < held_count; i++) begin
                  held_payload[i] = held_payload[i+1];
                  held_prio[i]    = held_prio[i+1];
               end
               held_count--;
            end
         end
         KIND_CLEAR: begin
            held_count = 0;
         end
         default: begin
         end
      endcase
      rsp.occupancy = held_count[OCC_BITS-1:0];
      awaited_rsps.push_back(rsp);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         awaited_rsps.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_result(req_kind, req_entry_payload, req_entry_priority);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               report_mismatch("response with nothing outstanding", 64'd0, 64'd0);
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_out_payload !== want.payload)
                  report_mismatch("out_payload", 64'(rsp_out_payload), 64'(want.payload));
               if (rsp_out_priority !== want.prio)
                  report_mismatch("out_priority", 64'(rsp_out_priority), 64'(want.prio));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch("occupancy", 64'(rsp_occupancy), 64'(want.occupancy));
            end
         end
      end
      pending_count = awaited_rsps.size();
   end

endmodule

[bench/tb_stable_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Drives enqueue, dequeue, clear and unused operations into the stable
// priority queue under random sender gaps and receiver stalls; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int PRIORITY_BITS  = 4;
   localparam int PAYLOAD_BITS   = 32;
   localparam int OCC_BITS       = $clog2(DEPTH + 1);
   localparam int RANDOM_OPS     = 650;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 4;

   // the block treats the spare kind code as no operation
   localparam logic [1:0] KIND_NOP = 2'd3;

   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic                      req_valid          = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_kind           = KIND_ENQ;
   logic [PAYLOAD_BITS-1:0]   req_entry_payload  = '0;
   logic [PRIORITY_BITS-1:0]  req_entry_priority = '0;
   logic                      rsp_valid;
   logic                      rsp_stall          = 1'b0;
   logic [PAYLOAD_BITS-1:0]   rsp_out_payload;
   logic [PRIORITY_BITS-1:0]  rsp_out_priority;
   logic [1:0]                rsp_status;
   logic [OCC_BITS-1:0]       rsp_occupancy;

   int fail_count;
   int pending_count;
   int tx_idle_pct = 10;
   int rx_idle_pct = 78;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   stable_priority_queue #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_entry_payload  (req_entry_payload),
      .req_entry_priority (req_entry_priority),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_status         (rsp_status),
      .rsp_occupancy      (rsp_occupancy)
   );

   spq_result_checker #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .OCC_BITS      (OCC_BITS)
   ) checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_entry_payload  (req_entry_payload),
      .req_entry_priority (req_entry_priority),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_status         (rsp_status),
      .rsp_occupancy      (rsp_occupancy),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);

   // end the run if neither channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a rising edge; returns at the edge that accepts the transaction
   task automatic issue_op(input logic [1:0] kind, input logic [PAYLOAD_BITS-1:0] payload,
                           input logic [PRIORITY_BITS-1:0] prio);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_entry_payload  <= payload;
      req_entry_priority <= prio;
      // stall is settled by the falling edge; hold until it drops
      do
         @(negedge clock);
      while (req_stall);
      @(posedge clock);
   endtask

   // hold the sender until every outstanding response has been taken
   task automatic await_drain();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return PAYLOAD_BITS'({$urandom, $urandom});
   endfunction

   function automatic logic [PRIORITY_BITS-1:0] pick_priority();
      // narrow range half the time so ties are common
      if ($urandom_range(0, 1) == 0)
         return PRIORITY_BITS'($urandom_range(0, 3));
      return PRIORITY_BITS'($urandom);
   endfunction

   // bursts that fill, drain or mix the queue, with rare clears and spare codes
   task automatic issue_random_ops(input int count);
      int         burst_left;
      int         mode;
      int         roll;
      logic [1:0] kind;
      burst_left = 0;
      mode       = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(4, 30);
            mode       = $urandom_range(0, 2);
         end
         burst_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            kind = KIND_CLEAR;
         else if (roll < 5)
            kind = KIND_NOP;
         else if (mode == 0)
            kind = (roll < 85) ? KIND_ENQ : KIND_DEQ;
         else if (mode == 1)
            kind = (roll < 20) ? KIND_ENQ : KIND_DEQ;
         else
            kind = (roll < 52) ? KIND_ENQ : KIND_DEQ;
         issue_op(kind, pick_payload(), pick_priority());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty dequeue, priority extremes, tie order, spare code, drain
      issue_op(KIND_DEQ, '0, '0);
      issue_op(KIND_ENQ, '0, '1);
      issue_op(KIND_ENQ, '1, '0);
      issue_op(KIND_ENQ, PAYLOAD_BITS'(1), '1);
      issue_op(KIND_NOP, pick_payload(), pick_priority());
      repeat (3) issue_op(KIND_DEQ, '1, '1);
      // fill, refuse one more, then clear a full queue
      for (int i = 0; i < DEPTH; i++)
         issue_op(KIND_ENQ, pick_payload(), PRIORITY_BITS'($urandom_range(0, 15)));
      issue_op(KIND_ENQ, '1, '0);
      issue_op(KIND_CLEAR, '0, '0);
      await_drain();

      issue_random_ops(RANDOM_OPS / 3);
      await_drain();

      tx_idle_pct = 78;
      rx_idle_pct = 10;
      issue_random_ops(RANDOM_OPS / 3);
      await_drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      issue_random_ops(RANDOM_OPS - 2 * (RANDOM_OPS / 3));
      await_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/stable_priority_queue.sv
bench/spq_result_checker.sv
bench/tb_stable_priority_queue.sv
